/* design/ede_pkg.sv */
`timescale 1ns / 1ps

package ede_pkg;

   localparam int MAX_LEN     = 32;
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SUM_W       = LEN_W + 1;
   localparam int CH_W        = 16;
   localparam int CMD_W       = 2;
   localparam int DIST_W      = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY  = 2'd0,
      CMD_WORD   = 2'd1,
      CMD_REPORT = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [CH_W-1:0] ch;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              truncated;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } result_push_type;

endpackage

/* design/ede_front.sv */
`timescale 1ns / 1ps

module ede_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [ede_pkg::CMD_W-1:0] req_cmd,
   input  logic [ede_pkg::CH_W-1:0]  req_ch,
   input  logic                      take,
   output ede_pkg::head_type         head
);

   ede_pkg::item_type               slot_ff [ede_pkg::QUEUE_DEPTH];
   logic [ede_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ede_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ede_pkg::CNT_W-1:0]       count_ff, count_in;
   ede_pkg::item_type               item_in;
   logic                            do_push;
   logic                            do_pop;

   // classify the raw command field
   assign item_in.cmd = ede_pkg::cmd_type'(req_cmd);
   assign item_in.ch  = req_ch;

   assign full    = (count_ff == ede_pkg::CNT_W'(ede_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = take && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ede_pkg::PTR_W'(ede_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ede_pkg::PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ede_pkg::PTR_W'(ede_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ede_pkg::PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + ede_pkg::CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - ede_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* design/ede_back.sv */
`timescale 1ns / 1ps

module ede_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ede_pkg::head_type        head,
   output logic                     take,
   input  logic                     rsp_full,
   output ede_pkg::result_push_type result_push
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FEED   = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [ede_pkg::LEN_W-1:0]        query_len_ff, query_len_in;
   logic [ede_pkg::LEN_W-1:0]        word_len_ff, word_len_in;
   logic                             overflow_ff, overflow_in;
   logic [ede_pkg::MAX_LEN-1:0]      row_valid_ff, row_valid_in;
   logic [ede_pkg::CH_W-1:0]         ch_ff, ch_in;
   logic [ede_pkg::IDX_W-1:0]        idx_ff;
   logic [ede_pkg::LEN_W-1:0]        prev_ff, prev_in;
   logic [ede_pkg::LEN_W-1:0]        diag_ff, diag_in;

   logic [ede_pkg::CH_W-1:0]         query_mem [ede_pkg::MAX_LEN];
   logic [ede_pkg::LEN_W-1:0]        row_mem [ede_pkg::MAX_LEN];
   logic [ede_pkg::CH_W-1:0]         qc_rd_ff;
   logic [ede_pkg::LEN_W-1:0]        row_rd_ff;
   logic                             row_rd_valid_ff;

   logic                             query_we;
   logic                             row_we;
   logic                             rd_en;
   logic [ede_pkg::IDX_W-1:0]        rd_addr;
   logic                             restart;
   logic [ede_pkg::IDX_W-1:0]        query_last;
   logic                             feed_last;
   logic [ede_pkg::LEN_W-1:0]        old_val;
   logic [ede_pkg::SUM_W-1:0]        up_cost, left_cost, diag_cost, min_ab, min_abc;
   logic [ede_pkg::LEN_W-1:0]        cell_new;

   assign query_last = ede_pkg::IDX_W'(query_len_ff - ede_pkg::LEN_W'(1));
   assign feed_last  = (idx_ff == query_last);

   // an entry not yet written since the last restart holds its index plus one
   assign old_val = row_rd_valid_ff ? row_rd_ff :
                    ede_pkg::LEN_W'(idx_ff) + ede_pkg::LEN_W'(1);

   // one cell of the row
   assign up_cost   = ede_pkg::SUM_W'(old_val) + ede_pkg::SUM_W'(1);
   assign left_cost = ede_pkg::SUM_W'(prev_ff) + ede_pkg::SUM_W'(1);
   assign diag_cost = ede_pkg::SUM_W'(diag_ff) + ede_pkg::SUM_W'(qc_rd_ff != ch_ff);
   assign min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
   assign min_abc   = (min_ab < diag_cost) ? min_ab : diag_cost;
   assign cell_new  = ede_pkg::LEN_W'(min_abc);

   always_comb begin
      state_in     = state_ff;
      query_len_in = query_len_ff;
      word_len_in  = word_len_ff;
      overflow_in  = overflow_ff;
      ch_in        = ch_ff;
      prev_in      = prev_ff;
      diag_in      = diag_ff;
      take         = 1'b0;
      query_we     = 1'b0;
      row_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      restart      = 1'b0;
      result_push  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            take = head.valid && !(head.item.cmd == ede_pkg::CMD_REPORT && rsp_full);
            if (take) begin
               unique case (head.item.cmd)
                  ede_pkg::CMD_QUERY: begin
                     if (query_len_ff < ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) begin
                        query_we     = 1'b1;
                        query_len_in = query_len_ff + ede_pkg::LEN_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                     restart = 1'b1;
                  end
                  ede_pkg::CMD_WORD: begin
                     if (word_len_ff >= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) begin
                        overflow_in = 1'b1;
                     end else if (query_len_ff == '0) begin
                        word_len_in = word_len_ff + ede_pkg::LEN_W'(1);
                     end else begin
                        ch_in    = head.item.ch;
                        prev_in  = word_len_ff + ede_pkg::LEN_W'(1);
                        diag_in  = word_len_ff;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_FEED;
                     end
                  end
                  ede_pkg::CMD_REPORT: begin
                     if (query_len_ff == '0) begin
                        result_push.valid              = 1'b1;
                        result_push.result.distance    = ede_pkg::DIST_W'(word_len_ff);
                        result_push.result.truncated   = overflow_ff;
                        restart                        = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = query_last;
                        state_in = ST_REPORT;
                     end
                  end
                  ede_pkg::CMD_CLEAR: begin
                     query_len_in = '0;
                     overflow_in  = 1'b0;
                     restart      = 1'b1;
                  end
               endcase
            end
         end
         ST_FEED: begin
            row_we  = 1'b1;
            diag_in = old_val;
            prev_in = cell_new;
            if (feed_last) begin
               word_len_in = word_len_ff + ede_pkg::LEN_W'(1);
               state_in    = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + ede_pkg::IDX_W'(1);
            end
         end
         ST_REPORT: begin
            result_push.valid            = 1'b1;
            result_push.result.distance  = ede_pkg::DIST_W'(old_val);
            result_push.result.truncated = overflow_ff;
            restart                      = 1'b1;
            state_in                     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         word_len_in = '0;
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (row_we) begin
         row_valid_in[idx_ff] = 1'b1;
      end
      if (restart) begin
         row_valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         query_len_ff <= '0;
         word_len_ff  <= '0;
         overflow_ff  <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         query_len_ff <= query_len_in;
         word_len_ff  <= word_len_in;
         overflow_ff  <= overflow_in;
         row_valid_ff <= row_valid_in;
      end
      ch_ff   <= ch_in;
      prev_ff <= prev_in;
      diag_ff <= diag_in;
   end

   // query and row stores, registered read
   always_ff @(posedge clock) begin
      if (query_we) begin
         query_mem[query_len_ff[ede_pkg::IDX_W-1:0]] <= head.item.ch;
      end
      if (row_we) begin
         row_mem[idx_ff] <= cell_new;
      end
      if (rd_en) begin
         qc_rd_ff        <= query_mem[rd_addr];
         row_rd_ff       <= row_mem[rd_addr];
         row_rd_valid_ff <= row_valid_in[rd_addr];
         idx_ff          <= rd_addr;
      end
   end

endmodule

/* design/ede_rsp_queue.sv */
`timescale 1ns / 1ps

module ede_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ede_pkg::result_push_type   result_push,
   output logic                       full,
   output logic                       empty,
   input  logic                       pop,
   output logic [ede_pkg::DIST_W-1:0] rsp_distance,
   output logic                       rsp_truncated
);

   ede_pkg::result_type             slot_ff [ede_pkg::QUEUE_DEPTH];
   logic [ede_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ede_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ede_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full    = (count_ff == ede_pkg::CNT_W'(ede_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = result_push.valid && !full;
   assign do_pop  = pop && !empty;

   assign rsp_distance  = slot_ff[rd_ptr_ff].distance;
   assign rsp_truncated = slot_ff[rd_ptr_ff].truncated;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ede_pkg::PTR_W'(ede_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ede_pkg::PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ede_pkg::PTR_W'(ede_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ede_pkg::PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + ede_pkg::CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - ede_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= result_push.result;
      end
   end

endmodule

/* design/edit_distance_engine_core.sv */
`timescale 1ns / 1ps
// Levenshtein edit distance between a stored query and a streamed word.
// Input channel: req_cmd / req_ch, transfer when push is high and full is low.
//   query char appends to the query, word char updates the distance row,
//   report ends the word and yields one result, clear empties query and word.
// Result channel: rsp_distance / rsp_truncated, valid while empty is low,
//   transfer when pop is high and empty is low.
// Commands pass through a two-entry queue into the execution unit, which
//   handles one command at a time; the row lives in a store with one read
//   and one write port, walked one cell per cycle.
// In the execution unit query char and clear finish in the idle state; a word
//   char then walks the feed state one cell per query char (not with an empty
//   query or a full word), a report reads the last cell and pushes its result
//   from the report state (at once from idle with an empty query).
// If the result side stalls, results gather in a two-entry queue; a report
//   then waits at the head of the input queue and full rises once that
//   queue has filled too.
// Synchronous reset empties both queues, clears query, word and flag;
//   full is low and empty is high in the first cycle after reset.
module edit_distance_engine_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [ede_pkg::CMD_W-1:0]  req_cmd,
   input  logic [ede_pkg::CH_W-1:0]   req_ch,
   output logic                       empty,
   input  logic                       pop,
   output logic [ede_pkg::DIST_W-1:0] rsp_distance,
   output logic                       rsp_truncated
);

   ede_pkg::head_type        head;
   logic                     take;
   logic                     rsp_full;
   ede_pkg::result_push_type result_push;

   ede_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_cmd (req_cmd),
      .req_ch  (req_ch),
      .take    (take),
      .head    (head)
   );

   ede_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .take        (take),
      .rsp_full    (rsp_full),
      .result_push (result_push)
   );

   ede_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .result_push   (result_push),
      .full          (rsp_full),
      .empty         (empty),
      .pop           (pop),
      .rsp_distance  (rsp_distance),
      .rsp_truncated (rsp_truncated)
   );

endmodule

/* design/ede_core_checker.sv */
`timescale 1ns / 1ps

module ede_core_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       push,
   input logic                       full,
   input logic [ede_pkg::CMD_W-1:0]  req_cmd,
   input logic [ede_pkg::CH_W-1:0]   req_ch,
   input logic                       empty,
   input logic                       pop,
   input logic [ede_pkg::DIST_W-1:0] rsp_distance,
   input logic                       rsp_truncated
);

   assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   assert property (@(posedge clock) reset |=> !full)
      else $error("input queue full after reset");

   assert property (@(posedge clock) push |-> !$isunknown({req_cmd, req_ch}))
      else $error("offered request has unknown fields");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_distance) && $stable(rsp_truncated)))
      else $error("waiting result changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((ede_pkg::MAX_LEN > 63) ||
                  (rsp_distance <= ede_pkg::DIST_W'(ede_pkg::MAX_LEN))))
      else $error("distance exceeds longest string");

endmodule

bind edit_distance_engine_core ede_core_checker u_checker (.*);
